[hw/rtl/lavr_pkg.sv]
// Package for the link availability / recovery mode tracker.
// Holds field widths, register reset values and the mode, reason, error and event codes.
// No dependencies.
package lavr_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned ATT_W  = 8;
	localparam int unsigned EV_W   = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST = ATT_W'(3);
	localparam logic [TIME_W-1:0] BASE_DELAY_RST   = TIME_W'(2000);
	localparam logic [TIME_W-1:0] MAX_DELAY_RST    = TIME_W'(8000);
	localparam logic              EXP_MODE_RST     = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_MODE     = 2'd3;

	localparam logic [EV_W-1:0] EV_UPDATE    = 4'd0;
	localparam logic [EV_W-1:0] EV_TICK      = 4'd1;
	localparam logic [EV_W-1:0] EV_TAKE      = 4'd2;
	localparam logic [EV_W-1:0] EV_STARTED   = 4'd3;
	localparam logic [EV_W-1:0] EV_COMPLETED = 4'd4;
	localparam logic [EV_W-1:0] EV_FAILED    = 4'd5;
	localparam logic [EV_W-1:0] EV_SUSPEND   = 4'd6;
	localparam logic [EV_W-1:0] EV_RESUME    = 4'd7;
	localparam logic [EV_W-1:0] EV_CLR_ERR   = 4'd8;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ONLINE  = 3'd1,
		MODE_LOCAL   = 3'd2,
		MODE_OFFLINE = 3'd3,
		MODE_RECOVER = 3'd4,
		MODE_SUSPEND = 3'd5,
		MODE_ERROR   = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		RSN_NONE       = 3'd0,
		RSN_INET_READY = 3'd1,
		RSN_INET_DOWN  = 3'd2,
		RSN_LOCAL_DOWN = 3'd3,
		RSN_NET_DOWN   = 3'd4,
		RSN_RESTORED   = 3'd5,
		RSN_FAILED     = 3'd6,
		RSN_MANUAL     = 3'd7
	} reason_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_RECOVERY = 2'd1,
		ERR_INTERNAL = 2'd2
	} error_t;

	typedef struct packed {
		logic             start;
		logic [ATT_W-1:0] attempt;
	} bo_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] delay;
	} bo_rsp_t;

endpackage

[hw/rtl/lavr_backoff.sv]
// Retry delay unit: in exponential mode the base delay is doubled once
// per earlier attempt, capped; fixed mode gives the base delay. One
// doubling step per cycle under a small sequencer. Depends on lavr_pkg.
module lavr_backoff import lavr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bo_req_t           req,
	input  logic [TIME_W-1:0] base_delay,
	input  logic [TIME_W-1:0] max_delay,
	input  logic              exp_mode,
	output bo_rsp_t           rsp
);

	typedef enum logic {BO_IDLE, BO_RUN} bo_state_t;

	bo_state_t         st_q;
	logic [TIME_W-1:0] d_q;
	logic [ATT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] res_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BO_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				BO_IDLE: begin
					if (req.start) begin
						if (!exp_mode || req.attempt <= ATT_W'(1)) begin
							res_q  <= base_delay;
							done_q <= 1'b1;
						end else begin
							d_q   <= base_delay;
							cnt_q <= req.attempt - ATT_W'(1);
							st_q  <= BO_RUN;
						end
					end
				end
				BO_RUN: begin
					if (cnt_q == '0) begin
						res_q  <= (d_q > max_delay) ? max_delay : d_q;
						done_q <= 1'b1;
						st_q   <= BO_IDLE;
					end else if (d_q >= max_delay || d_q > (max_delay >> 1)) begin
						res_q  <= max_delay;
						done_q <= 1'b1;
						st_q   <= BO_IDLE;
					end else begin
						d_q   <= d_q << 1;
						cnt_q <= cnt_q - ATT_W'(1);
					end
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.delay = res_q;

endmodule

[hw/rtl/link_availability_recovery_fsm_unit.sv]
// Top level of the link availability / recovery mode tracker.
// Uses lavr_pkg and lavr_backoff (retry delay sequencer).
//
// channel | signals                          | direction
// in      | in_valid/in_ready, event fields  | event item in
// out     | out_valid/out_ready, state view  | result item out
// cfg     | cfg_we, cfg_index, cfg_wdata     | register write
//
// Most events are applied at the accepting edge; the result is valid the next cycle.
// A failed recovery that schedules a retry runs the backoff sequencer, one doubling
// step per cycle, stopping early in fixed mode or once the cap is reached; the result
// is valid after the sequencer's done strobe has been registered into the output.
// in_ready is low while the sequencer runs and while an unclaimed result blocks the
// output register. Reset clears the state but the stored event time, and loads register defaults.
module link_availability_recovery_fsm_unit import lavr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [EV_W-1:0]      req_type,
	input  logic                 network_up,
	input  logic                 local_up,
	input  logic                 internet_up,
	input  logic                 snapshot_absent,
	input  logic [TIME_W-1:0]    now_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           mode_code,
	output logic [2:0]           reason_code,
	output logic [1:0]           error_code,
	output logic                 request_pending,
	output logic                 recovery_active,
	output logic [ATT_W-1:0]     attempt_number,
	output logic [TIME_W-1:0]    retry_delay_ms,
	output logic [TIME_W-1:0]    retry_due_ms,
	output logic [CNT_W-1:0]     transition_total,
	output logic [CNT_W-1:0]     recovery_total,
	output logic [CNT_W-1:0]     generation_count,
	output logic                 request_granted,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_wdata
);

	typedef enum logic {S_IDLE, S_BUSY} state_t;

	state_t            st_q;
	logic              out_valid_q;
	logic [ATT_W-1:0]  max_att_q;
	logic [TIME_W-1:0] base_q, maxd_q;
	logic              exp_q;

	mode_t             mode_q;
	reason_t           reason_q;
	error_t            error_q;
	logic [2:0]        flags_q;
	logic              pend_q, act_q, granted_q;
	logic [ATT_W-1:0]  att_q;
	logic [TIME_W-1:0] delay_q, due_q, now_q;
	logic [CNT_W-1:0]  trans_q, rec_q, gen_q;

	mode_t             mode_n, tgt_m;
	reason_t           reason_n, tgt_r;
	error_t            error_n;
	logic [2:0]        flags_n, in_flags;
	logic              pend_n, act_n, granted_n;
	logic [ATT_W-1:0]  att_n;
	logic [TIME_W-1:0] delay_n, due_n;
	logic [CNT_W-1:0]  rec_n;
	logic              do_go, gen_inc, start_bo, limited, clear_rt;

	bo_req_t bo_req;
	bo_rsp_t bo_rsp;

	wire in_acc  = in_valid && in_ready;
	wire out_acc = out_valid_q && out_ready;

	assign in_ready = (st_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_flags = {internet_up, local_up, network_up};

	always_comb begin
		mode_n    = mode_q;
		reason_n  = reason_q;
		error_n   = error_q;
		flags_n   = flags_q;
		pend_n    = pend_q;
		act_n     = act_q;
		att_n     = att_q;
		delay_n   = delay_q;
		due_n     = due_q;
		rec_n     = rec_q;
		granted_n = 1'b0;
		tgt_m     = mode_q;
		tgt_r     = reason_q;
		do_go     = 1'b0;
		gen_inc   = 1'b0;
		start_bo  = 1'b0;
		limited   = 1'b0;
		clear_rt  = 1'b0;
		case (req_type)
			EV_UPDATE, EV_RESUME: begin
				if (req_type == EV_RESUME) begin
					mode_n   = MODE_IDLE;
					reason_n = RSN_NONE;
				end
				if (snapshot_absent) begin
					error_n = ERR_INTERNAL;
					do_go   = 1'b1;
					tgt_m   = MODE_ERROR;
					tgt_r   = RSN_NONE;
				end else if (mode_n == MODE_SUSPEND) begin
					flags_n = in_flags;
					gen_inc = 1'b1;
				end else begin
					limited = mode_n == MODE_LOCAL || mode_n == MODE_OFFLINE ||
						mode_n == MODE_RECOVER || error_q == ERR_RECOVERY;
					flags_n = in_flags;
					error_n = ERR_NONE;
					do_go   = 1'b1;
					if (!network_up) begin
						clear_rt = 1'b1;
						tgt_m    = MODE_OFFLINE;
						tgt_r    = RSN_NET_DOWN;
					end else if (!internet_up) begin
						clear_rt = 1'b1;
						tgt_m    = local_up ? MODE_LOCAL : MODE_OFFLINE;
						tgt_r    = local_up ? RSN_INET_DOWN : RSN_LOCAL_DOWN;
					end else if (limited) begin
						act_n   = 1'b0;
						pend_n  = 1'b1;
						att_n   = (att_q == '0) ? ATT_W'(1) : att_q;
						delay_n = '0;
						due_n   = now_ms;
						tgt_m   = MODE_RECOVER;
						tgt_r   = RSN_RESTORED;
					end else begin
						clear_rt = 1'b1;
						tgt_m    = MODE_ONLINE;
						tgt_r    = RSN_INET_READY;
					end
				end
			end
			EV_TICK: begin
				if (mode_q == MODE_RECOVER && !act_q && !pend_q && flags_q[0] &&
					flags_q[2] && due_q != '0 && now_ms >= due_q) begin
					delay_n = '0;
					due_n   = '0;
					pend_n  = 1'b1;
					gen_inc = 1'b1;
				end
			end
			EV_TAKE: begin
				if (pend_q) begin
					pend_n    = 1'b0;
					act_n     = 1'b1;
					gen_inc   = 1'b1;
					granted_n = 1'b1;
				end
			end
			EV_STARTED: begin
				if (mode_q == MODE_RECOVER) begin
					pend_n  = 1'b0;
					act_n   = 1'b1;
					gen_inc = 1'b1;
				end
			end
			EV_COMPLETED: begin
				if (flags_q[0] && flags_q[2]) begin
					clear_rt = 1'b1;
					rec_n    = rec_q + CNT_W'(1);
					error_n  = ERR_NONE;
					do_go    = 1'b1;
					tgt_m    = MODE_ONLINE;
					tgt_r    = RSN_INET_READY;
				end
			end
			EV_FAILED: begin
				if (mode_q == MODE_RECOVER) begin
					pend_n  = 1'b0;
					act_n   = 1'b0;
					error_n = ERR_RECOVERY;
					if (flags_q[0] && flags_q[2]) begin
						if (att_q >= max_att_q) begin
							delay_n = '0;
							due_n   = '0;
							do_go   = 1'b1;
							tgt_m   = MODE_RECOVER;
							tgt_r   = RSN_FAILED;
						end else begin
							// delay, due time and the transition land when the unit finishes
							att_n    = att_q + ATT_W'(1);
							start_bo = 1'b1;
						end
					end
				end
			end
			EV_SUSPEND: begin
				pend_n = 1'b0;
				act_n  = 1'b0;
				do_go  = 1'b1;
				tgt_m  = MODE_SUSPEND;
				tgt_r  = RSN_MANUAL;
			end
			EV_CLR_ERR: begin
				error_n = ERR_NONE;
				gen_inc = 1'b1;
			end
			default: ;
		endcase
		if (clear_rt) begin
			pend_n  = 1'b0;
			act_n   = 1'b0;
			att_n   = '0;
			delay_n = '0;
			due_n   = '0;
		end
	end

	assign bo_req.start   = in_acc && start_bo;
	assign bo_req.attempt = att_q;

	lavr_backoff u_backoff (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (bo_req),
		.base_delay (base_q),
		.max_delay  (maxd_q),
		.exp_mode   (exp_q),
		.rsp        (bo_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
			max_att_q   <= MAX_ATTEMPTS_RST;
			base_q      <= BASE_DELAY_RST;
			maxd_q      <= MAX_DELAY_RST;
			exp_q       <= EXP_MODE_RST;
			mode_q      <= MODE_IDLE;
			reason_q    <= RSN_NONE;
			error_q     <= ERR_NONE;
			flags_q     <= '0;
			pend_q      <= 1'b0;
			act_q       <= 1'b0;
			granted_q   <= 1'b0;
			att_q       <= '0;
			delay_q     <= '0;
			due_q       <= '0;
			trans_q     <= '0;
			rec_q       <= '0;
			gen_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_ATTEMPTS: max_att_q <= cfg_wdata[ATT_W-1:0];
					CFG_BASE_DELAY:   base_q    <= cfg_wdata;
					CFG_MAX_DELAY:    maxd_q    <= cfg_wdata;
					CFG_EXP_MODE:     exp_q     <= cfg_wdata[0];
				endcase
			end
			if (out_acc && !in_acc)
				out_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q    <= do_go ? tgt_m : mode_n;
						reason_q  <= do_go ? tgt_r : reason_n;
						error_q   <= error_n;
						flags_q   <= flags_n;
						pend_q    <= pend_n;
						act_q     <= act_n;
						att_q     <= att_n;
						delay_q   <= delay_n;
						due_q     <= due_n;
						rec_q     <= rec_n;
						granted_q <= granted_n;
						now_q     <= now_ms;
						if (do_go && (tgt_m != mode_n || tgt_r != reason_n))
							trans_q <= trans_q + CNT_W'(1);
						if (do_go || gen_inc)
							gen_q <= gen_q + CNT_W'(1);
						if (start_bo) begin
							st_q        <= S_BUSY;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_BUSY: begin
					if (bo_rsp.done) begin
						delay_q  <= bo_rsp.delay;
						due_q    <= now_q + bo_rsp.delay;
						reason_q <= RSN_FAILED;
						if (reason_q != RSN_FAILED)
							trans_q <= trans_q + CNT_W'(1);
						gen_q       <= gen_q + CNT_W'(1);
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign mode_code        = mode_q;
	assign reason_code      = reason_q;
	assign error_code       = error_q;
	assign request_pending  = pend_q;
	assign recovery_active  = act_q;
	assign attempt_number   = att_q;
	assign retry_delay_ms   = delay_q;
	assign retry_due_ms     = due_q;
	assign transition_total = trans_q;
	assign recovery_total   = rec_q;
	assign generation_count = gen_q;
	assign request_granted  = granted_q;

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_BUSY) |-> !out_valid_q)
		else $error("result shown while backoff runs");

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bo_rsp.done |-> (st_q == S_BUSY))
		else $error("backoff finished outside a failed event");

	a_grant_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && granted_q) |-> (act_q && !pend_q))
		else $error("grant without active recovery");

	a_busy_recover: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_BUSY) |-> (mode_q == MODE_RECOVER && error_q == ERR_RECOVERY))
		else $error("backoff running outside recovery");

endmodule
